@@ rtl/core/spe_pkg.sv @@
// ----------------------------------------------------------------------------
// spe_pkg
// shared constants, op codes, state type and control structs for the
// shortest path engine
// ----------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;
    localparam int DEF_COST_BITS = 32;
    localparam int DEF_DIST_BITS = 48;

    localparam int NODE_PORT_W = 6;
    localparam int COST_PORT_W = 32;
    localparam int CFG_W       = 7;
    localparam int OP_W        = 2;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PICK,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_RELAX
    } state_t;

    typedef struct packed {
        logic load_edge;
        logic clear_graph;
        logic q_init;
        logic scan_start;
        logic scan_step;
        logic settle;
        logic edge_start;
        logic edge_issue;
        logic edge_next;
        logic relax_issue;
        logic relax_write;
        logic finish_found;
        logic finish_none;
    } cmd_t;

    typedef struct packed {
        logic q_bad;
        logic scan_last;
        logic found;
        logic pick_is_dst;
        logic edge_empty;
        logic edge_last;
        logic relax_ok;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/spe_ctrl.sv @@
// ----------------------------------------------------------------------------
// spe_ctrl
// query sequencer: minimum scan, settle, edge walk and relax steps
// ----------------------------------------------------------------------------
`default_nettype none

module spe_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [spe_pkg::OP_W-1:0] op,
    input  wire spe_pkg::status_t         status,
    output spe_pkg::cmd_t                 cmd,
    output logic                          busy
);
    import spe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_CLEAR: cmd.clear_graph = 1'b1;
                        OP_ADD:   cmd.load_edge   = 1'b1;
                        OP_QUERY:
                        begin
                            if (status.q_bad)
                            begin
                                cmd.finish_none = 1'b1;
                            end
                            else
                            begin
                                cmd.q_init     = 1'b1;
                                cmd.scan_start = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (!status.found)
                begin
                    cmd.finish_none = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.settle = 1'b1;
                    if (status.pick_is_dst)
                    begin
                        cmd.finish_found = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    else if (status.edge_empty)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.edge_start = 1'b1;
                        state_next     = ST_EDGE_RD;
                    end
                end
            end
            ST_EDGE_RD:
            begin
                cmd.edge_issue = 1'b1;
                state_next     = ST_EDGE_CHK;
            end
            ST_EDGE_CHK, ST_RELAX:
            begin
                if ((state_reg == ST_EDGE_CHK) && status.relax_ok)
                begin
                    cmd.relax_issue = 1'b1;
                    state_next      = ST_RELAX;
                end
                else
                begin
                    cmd.relax_write = (state_reg == ST_RELAX);
                    if (status.edge_last)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.edge_next = 1'b1;
                        state_next    = ST_EDGE_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/spe_datapath.sv @@
// ----------------------------------------------------------------------------
// spe_datapath
// edge table, distance memory, node marks, scan and relax arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module spe_datapath #(
    parameter int MAX_NODES = spe_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = spe_pkg::DEF_MAX_EDGES,
    parameter int COST_BITS = spe_pkg::DEF_COST_BITS,
    parameter int DIST_BITS = spe_pkg::DEF_DIST_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [spe_pkg::CFG_W-1:0]       cfg_wr_data,
    input  wire logic [spe_pkg::NODE_PORT_W-1:0] node_a,
    input  wire logic [spe_pkg::NODE_PORT_W-1:0] node_b,
    input  wire logic [spe_pkg::COST_PORT_W-1:0] edge_cost,
    input  wire spe_pkg::cmd_t                   cmd,
    output spe_pkg::status_t                     status,
    output logic                                 done,
    output logic [DIST_BITS-1:0]                 path_length,
    output logic                                 reachable,
    output logic                                 edges_dropped
);
    import spe_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int NCNT_W = $clog2(MAX_NODES + 1);
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int SUM_W  = ((DIST_BITS > COST_BITS) ? DIST_BITS : COST_BITS) + 1;
    localparam int CMP_W  = ((NCNT_W > CFG_W) ? NCNT_W : CFG_W) + 1;

    // edge table
    logic [NODE_PORT_W-1:0] e1_mem [MAX_EDGES];
    logic [NODE_PORT_W-1:0] e2_mem [MAX_EDGES];
    logic [COST_BITS-1:0]   w_mem  [MAX_EDGES];
    logic [NODE_PORT_W-1:0] e1_q;
    logic [NODE_PORT_W-1:0] e2_q;
    logic [COST_BITS-1:0]   w_q;
    logic [ECNT_W-1:0]      edge_total_reg;
    logic                   overflow_reg;
    logic [EIDX_W-1:0]      e_reg;

    // node state
    logic [DIST_BITS-1:0]   dist_mem [MAX_NODES];
    logic [DIST_BITS-1:0]   dist_q;
    logic [MAX_NODES-1:0]   reached_reg;
    logic [MAX_NODES-1:0]   settled_reg;
    logic [CFG_W-1:0]       node_count_reg;

    // scan and relax registers
    logic [NODE_W-1:0]      scan_i_reg;
    logic [NODE_W-1:0]      idx_d_reg;
    logic                   sv_reg;
    logic                   found_reg;
    logic [NODE_W-1:0]      pick_reg;
    logic [DIST_BITS-1:0]   pick_dist_reg;
    logic [NODE_W-1:0]      dst_reg;
    logic [NODE_W-1:0]      to_reg;

    // result registers
    logic                   done_reg;
    logic [DIST_BITS-1:0]   len_reg;
    logic                   reach_reg;
    logic                   drop_reg;

    logic [CMP_W-1:0]       nc_ext;
    logic [CMP_W-1:0]       limit;
    logic                   edge_room;
    logic                   take_scan;
    logic [CMP_W-1:0]       pick_ext;
    logic                   m1;
    logic                   m2;
    logic [CMP_W-1:0]       other_ext;
    logic [NODE_W-1:0]      other_idx;
    logic [NODE_W-1:0]      rd_addr;
    logic [SUM_W-1:0]       sum;
    logic [DIST_BITS-1:0]   cand;
    logic                   improve;
    logic                   dist_we;
    logic [NODE_W-1:0]      dist_waddr;
    logic [DIST_BITS-1:0]   dist_wdata;

    // node count clamped to one through the node capacity
    always_comb
    begin
        nc_ext = CMP_W'(node_count_reg);
        if (nc_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (nc_ext > CMP_W'(MAX_NODES))
        begin
            limit = CMP_W'(MAX_NODES);
        end
        else
        begin
            limit = nc_ext;
        end
    end

    assign edge_room = (edge_total_reg < ECNT_W'(MAX_EDGES));

    assign take_scan = sv_reg && reached_reg[idx_d_reg] && !settled_reg[idx_d_reg]
                       && (!found_reg || (dist_q < pick_dist_reg));

    assign pick_ext  = CMP_W'(pick_reg);
    assign m1        = (CMP_W'(e1_q) == pick_ext);
    assign m2        = (CMP_W'(e2_q) == pick_ext);
    assign other_ext = m1 ? CMP_W'(e2_q) : CMP_W'(e1_q);
    assign other_idx = NODE_W'(other_ext);

    assign rd_addr = cmd.relax_issue ? other_idx : scan_i_reg;

    assign sum  = SUM_W'(pick_dist_reg) + SUM_W'(w_q);
    assign cand = (sum > SUM_W'({DIST_BITS{1'b1}})) ? {DIST_BITS{1'b1}}
                                                      : sum[DIST_BITS-1:0];
    assign improve = !reached_reg[to_reg] || (cand < dist_q);

    always_comb
    begin
        dist_we    = 1'b0;
        dist_waddr = to_reg;
        dist_wdata = cand;
        if (cmd.q_init)
        begin
            dist_we    = 1'b1;
            dist_waddr = NODE_W'(node_a);
            dist_wdata = '0;
        end
        else if (cmd.relax_write && improve)
        begin
            dist_we = 1'b1;
        end
    end

    always_comb
    begin
        status.q_bad       = (CMP_W'(node_a) >= limit) || (CMP_W'(node_b) >= limit);
        status.scan_last   = (CMP_W'(scan_i_reg) == (limit - CMP_W'(1)));
        status.found       = found_reg;
        status.pick_is_dst = (pick_reg == dst_reg);
        status.edge_empty  = (edge_total_reg == '0);
        status.edge_last   = (ECNT_W'(e_reg) == (edge_total_reg - ECNT_W'(1)));
        status.relax_ok    = (m1 || m2) && (other_ext < limit) && !settled_reg[other_idx];
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_edge && edge_room)
        begin
            e1_mem[edge_total_reg[EIDX_W-1:0]] <= node_a;
            e2_mem[edge_total_reg[EIDX_W-1:0]] <= node_b;
            w_mem[edge_total_reg[EIDX_W-1:0]]  <= edge_cost[COST_BITS-1:0];
        end
        if (cmd.edge_issue)
        begin
            e1_q <= e1_mem[e_reg];
            e2_q <= e2_mem[e_reg];
            w_q  <= w_mem[e_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_q <= dist_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            reached_reg    <= '0;
            settled_reg    <= '0;
            sv_reg         <= 1'b0;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
            if (cmd.clear_graph)
            begin
                edge_total_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            else if (cmd.load_edge)
            begin
                if (edge_room)
                begin
                    edge_total_reg <= edge_total_reg + ECNT_W'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (cmd.q_init)
            begin
                // only the source starts out reached
                reached_reg <= {{(MAX_NODES-1){1'b0}}, 1'b1} << node_a;
                settled_reg <= '0;
            end
            else
            begin
                if (cmd.relax_write && improve)
                begin
                    reached_reg[to_reg] <= 1'b1;
                end
                if (cmd.settle)
                begin
                    settled_reg[pick_reg] <= 1'b1;
                end
            end
            sv_reg <= cmd.scan_step;
            if (cmd.scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (take_scan)
            begin
                found_reg <= 1'b1;
            end
            done_reg <= cmd.finish_found || cmd.finish_none;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.q_init)
        begin
            dst_reg <= NODE_W'(node_b);
        end
        if (cmd.scan_start)
        begin
            scan_i_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_i_reg <= scan_i_reg + NODE_W'(1);
        end
        idx_d_reg <= scan_i_reg;
        if (take_scan)
        begin
            pick_reg      <= idx_d_reg;
            pick_dist_reg <= dist_q;
        end
        if (cmd.edge_start)
        begin
            e_reg <= '0;
        end
        else if (cmd.edge_next)
        begin
            e_reg <= e_reg + EIDX_W'(1);
        end
        if (cmd.relax_issue)
        begin
            to_reg <= other_idx;
        end
        if (cmd.finish_found || cmd.finish_none)
        begin
            len_reg   <= cmd.finish_found ? pick_dist_reg : '0;
            reach_reg <= cmd.finish_found;
            drop_reg  <= overflow_reg;
        end
    end

    assign done          = done_reg;
    assign path_length   = len_reg;
    assign reachable     = reach_reg;
    assign edges_dropped = drop_reg;

endmodule

`default_nettype wire

@@ rtl/core/shortest_path_engine.sv @@
// ----------------------------------------------------------------------------
// shortest_path_engine
// single-pair shortest path over a stored undirected weighted graph
// ----------------------------------------------------------------------------
//
// channel  | signals                                      | handshake
// ---------+----------------------------------------------+---------------------
// command  | op, node_a, node_b, edge_cost                | start & !busy
// result   | path_length, reachable, edges_dropped        | done, one cycle
// config   | cfg_wr_data (node_count)                     | cfg_wr_en
//
// clear and add words never raise busy
// a query runs rounds of: node scan (ST_SCAN, ST_DRAIN), settle (ST_PICK), then
// per stored edge a read and a check, plus a relax step for a relaxed neighbor
// the result word shows in the cycle after the round that settles the target
// or finds no reachable node; a bad source or target answers in the next cycle
// reset is asynchronous and needs no clearing pass; the result cannot stall
`default_nettype none

module shortest_path_engine #(
    parameter int MAX_NODES = spe_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = spe_pkg::DEF_MAX_EDGES,
    parameter int COST_BITS = spe_pkg::DEF_COST_BITS,
    parameter int DIST_BITS = spe_pkg::DEF_DIST_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [spe_pkg::OP_W-1:0]        op,
    input  wire logic [spe_pkg::NODE_PORT_W-1:0] node_a,
    input  wire logic [spe_pkg::NODE_PORT_W-1:0] node_b,
    input  wire logic [spe_pkg::COST_PORT_W-1:0] edge_cost,
    input  wire logic                            cfg_wr_en,
    input  wire logic [spe_pkg::CFG_W-1:0]       cfg_wr_data,
    output logic                                 done,
    output logic [DIST_BITS-1:0]                 path_length,
    output logic                                 reachable,
    output logic                                 edges_dropped
);
    import spe_pkg::*;

    // commands from the sequencer, flags back from the datapath
    cmd_t    cmd;
    status_t status;

    spe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    spe_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES),
        .COST_BITS (COST_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .node_a        (node_a),
        .node_b        (node_b),
        .edge_cost     (edge_cost),
        .cmd           (cmd),
        .status        (status),
        .done          (done),
        .path_length   (path_length),
        .reachable     (reachable),
        .edges_dropped (edges_dropped)
    );

endmodule

`default_nettype wire

@@ rtl/core/spe_checker.sv @@
// ----------------------------------------------------------------------------
// spe_checker
// port level checks on command and result timing
// ----------------------------------------------------------------------------
`default_nettype none

module spe_checker #(
    parameter int DIST_BITS = spe_pkg::DEF_DIST_BITS
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic [spe_pkg::OP_W-1:0] op,
    input wire logic                     done,
    input wire logic [DIST_BITS-1:0]     path_length,
    input wire logic                     reachable
);
    import spe_pkg::*;

    // a result word only follows a query
    a_done_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && !busy && (op == OP_QUERY))))
        else $error("result without a query");

    // unreachable answers carry zero length
    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !reachable) |-> (path_length == '0))
        else $error("unreachable result with nonzero length");

    // a query ends only with its result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query ended without a result");

    // clear and add words never hold the engine
    a_edit_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != OP_QUERY)) |=> !busy)
        else $error("edit word raised busy");

endmodule

bind shortest_path_engine spe_checker #(.DIST_BITS(DIST_BITS)) u_spe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .done        (done),
    .path_length (path_length),
    .reachable   (reachable)
);

`default_nettype wire
